### hdl/rpb_pkg.sv
// rpb_pkg: shared constants, mode codes and types for the RGB565 blend unit.
// No dependencies; used by rgb565_pixel_blend and rpb_blend.
`default_nettype none

package rpb_pkg;

  localparam int unsigned PixW  = 16;
  localparam int unsigned RndW  = 8;
  localparam int unsigned ModeW = 4;

  localparam logic [ModeW-1:0] MODE_REPLACE = 4'd0;
  localparam logic [ModeW-1:0] MODE_XOR     = 4'd1;
  localparam logic [ModeW-1:0] MODE_OR      = 4'd2;
  localparam logic [ModeW-1:0] MODE_AND     = 4'd3;
  localparam logic [ModeW-1:0] MODE_HALFQTR = 4'd4;
  localparam logic [ModeW-1:0] MODE_HALF    = 4'd5;
  localparam logic [ModeW-1:0] MODE_QUARTER = 4'd6;
  localparam logic [ModeW-1:0] MODE_SATADD  = 4'd7;
  localparam logic [ModeW-1:0] MODE_SATSUB  = 4'd8;
  localparam logic [ModeW-1:0] MODE_NOISE   = 4'd9;

  localparam logic [15:0] MASK_HALF    = 16'hF7DF;
  localparam logic [15:0] MASK_QUARTER = 16'hE79F;
  localparam logic [15:0] MASK_NOLSB   = 16'hF7DE;
  localparam logic [16:0] MASK_CARRY   = 17'h10820;
  localparam logic [31:0] MASK_BORROW  = 32'hFFFEF7DF;

  localparam logic [4:0] CH5_MAX = 5'h1F;
  localparam logic [5:0] CH6_MAX = 6'h3F;

  typedef struct packed {
    logic [PixW-1:0] dest_pixel;
    logic [PixW-1:0] source_color;
    logic [RndW-1:0] random_byte;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] new_pixel;
    logic            mode_unsupported;
  } pix_out_t;

endpackage

`default_nettype wire

### hdl/rgb565_pixel_blend.sv
// rgb565_pixel_blend: top level, input register, blend datapath, output register.
// Depends on rpb_pkg and rpb_blend.
//
// Usage:
//  - s_axis: one input word per handshake; tdata = dest_pixel [15:0],
//    source_color [31:16], random_byte [39:32].
//  - m_axis: one result word per input word; tdata = new_pixel,
//    tuser = mode_unsupported.
//  - cfg: write channel for blend_mode (cfg_data_i), always ready; write it
//    only while no word is in flight.
//  - Path: an accepted word passes the input register, then the output register, before m_axis_tvalid.
//  - Throughput: 1 word per cycle while m_axis_tready is high, set by the two-register pipeline with
//    the combinational blend logic between them.
//  - Stall: while m_axis_tready is low the result holds; if the input register is empty, one more word
//    is taken into it, then s_axis_tready drops.
//  - Reset: both stages empty, blend_mode = 0 (replace), s_axis_tready low
//    while rst_ni is asserted.
`default_nettype none

module rgb565_pixel_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // dest_pixel, source_color, random_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,  // new_pixel
  output      logic        m_axis_tuser,  // mode_unsupported
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i
);

  logic [rpb_pkg::ModeW-1:0] mode_q;
  logic                      in_vld_q, out_vld_q;
  rpb_pkg::pix_in_t          in_q;
  rpb_pkg::pix_out_t         res_d, res_q;
  logic                      out_take, in_take;

  assign out_take      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = rst_ni && (!in_vld_q || out_take);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= rpb_pkg::MODE_REPLACE;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_take) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.dest_pixel   <= s_axis_tdata[15:0];
      in_q.source_color <= s_axis_tdata[31:16];
      in_q.random_byte  <= s_axis_tdata[39:32];
    end
    if (out_take && in_vld_q) res_q <= res_d;
  end

  rpb_blend u_blend (
    .mode_i (mode_q),
    .pix_i  (in_q),
    .pix_o  (res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q.new_pixel;
  assign m_axis_tuser  = res_q.mode_unsupported;

endmodule

`default_nettype wire

### hdl/rpb_blend.sv
// rpb_blend: combinational RGB565 blend datapath, one word in, one result out.
// Depends on rpb_pkg.
`default_nettype none

module rpb_blend (
  input  wire logic [rpb_pkg::ModeW-1:0] mode_i,
  input  wire rpb_pkg::pix_in_t          pix_i,
  output rpb_pkg::pix_out_t              pix_o
);

  logic [15:0] d, s;
  logic [2:0]  n;
  logic [16:0] add_c, add_m;
  logic [31:0] sub_c, sub_m, sub_r;
  logic [15:0] half_t, qtr_t;
  logic [6:0]  nb, ng, nr;
  logic [4:0]  cb, cr;
  logic [5:0]  cg;

  always_comb begin
    d = pix_i.dest_pixel;
    s = pix_i.source_color;
    n = pix_i.random_byte[7:5];

    half_t = (d & rpb_pkg::MASK_HALF) >> 1;
    qtr_t  = (d & rpb_pkg::MASK_QUARTER) >> 2;

    // saturating add: carry out of each channel smeared downwards
    add_c = {1'b0, s} + {1'b0, d & rpb_pkg::MASK_NOLSB};
    add_m = add_c & rpb_pkg::MASK_CARRY;

    // saturating subtract: borrow into each channel clears it
    sub_c = {15'd0, {1'b0, d} | rpb_pkg::MASK_CARRY} - {16'd0, s};
    sub_m = sub_c | rpb_pkg::MASK_BORROW;
    sub_r = sub_c & (sub_m >> 1) & (sub_m >> 2) & (sub_m >> 3);

    // noise: 3/4 of each channel plus noise, clamped
    nb = 7'(3 * {4'd0, d[4:2]})   + {4'd0, n};
    ng = 7'(3 * {3'd0, d[10:7]})  + {3'd0, n, 1'b0};
    nr = 7'(3 * {4'd0, d[15:13]}) + {4'd0, n};
    cb = (nb > 7'(rpb_pkg::CH5_MAX)) ? rpb_pkg::CH5_MAX : nb[4:0];
    cg = (ng > 7'(rpb_pkg::CH6_MAX)) ? rpb_pkg::CH6_MAX : ng[5:0];
    cr = (nr > 7'(rpb_pkg::CH5_MAX)) ? rpb_pkg::CH5_MAX : nr[4:0];

    pix_o.mode_unsupported = 1'b0;
    case (mode_i)
      rpb_pkg::MODE_REPLACE: pix_o.new_pixel = s;
      rpb_pkg::MODE_XOR:     pix_o.new_pixel = d ^ s;
      rpb_pkg::MODE_OR:      pix_o.new_pixel = d | s;
      rpb_pkg::MODE_AND:     pix_o.new_pixel = d & s;
      rpb_pkg::MODE_HALFQTR: pix_o.new_pixel = half_t + qtr_t + s;
      rpb_pkg::MODE_HALF:    pix_o.new_pixel = s + half_t;
      rpb_pkg::MODE_QUARTER: pix_o.new_pixel = s + qtr_t;
      rpb_pkg::MODE_SATADD: begin
        pix_o.new_pixel = (add_c[15:0] & rpb_pkg::MASK_NOLSB) | add_m[16:1]
                          | {1'b0, add_m[16:2]} | {2'b0, add_m[16:3]};
      end
      rpb_pkg::MODE_SATSUB:  pix_o.new_pixel = sub_r[15:0] & rpb_pkg::MASK_NOLSB;
      rpb_pkg::MODE_NOISE:   pix_o.new_pixel = {cr, cg, cb};
      default: begin
        pix_o.new_pixel        = d;
        pix_o.mode_unsupported = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/rpb_checker.sv
// rpb_checker: port-level assertions for rgb565_pixel_blend, bound to the top level.
// Depends on nothing but the top level's port list.
`default_nettype none

module rpb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed under stall");

  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !s_axis_tready ##1 !m_axis_tvalid)
    else $error("handshake active in reset");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without input word two cycles before");

endmodule

bind rgb565_pixel_blend rpb_checker u_rpb_checker (.*);

`default_nettype wire
